FILE: rtl/lrupr_pkg.sv
`timescale 1ns / 1ps

package lrupr_pkg;

  localparam int PAGE_W       = 8;
  localparam int SLOT_W       = 3;
  localparam int CFG_W        = 4;
  localparam int FAULT_W      = 32;
  localparam int FRAMES_RESET = 8;

  // Largest frame count the cell chain supports; indices and ranks are sized for it.
  localparam int FRAMES_LIMIT = 64;
  localparam int IDX_W        = $clog2(FRAMES_LIMIT);
  localparam int RANK_W       = $clog2(FRAMES_LIMIT);

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [RANK_W-1:0] rank_t;

  // Record that travels down the chain, one cell per cycle.
  typedef struct packed {
    logic  found;
    idx_t  found_idx;
    rank_t found_rank;
    logic  free;
    idx_t  free_idx;
    logic  best_set;
    idx_t  best_idx;
    rank_t best_rank;
    page_t best_page;
  } scan_t;

  // Update broadcast to every cell once the scan is done.
  typedef struct packed {
    logic  en;
    logic  miss;
    idx_t  use_idx;
    rank_t limit;
  } cmd_t;

endpackage

FILE: rtl/lrupr_cell.sv
`timescale 1ns / 1ps

module lrupr_cell #(
  parameter int MAX_FRAMES = 8,
  parameter int CELL_INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            active,
  input  lrupr_pkg::page_t page,
  input  lrupr_pkg::scan_t scan_in,
  output lrupr_pkg::scan_t scan_out,
  input  lrupr_pkg::cmd_t  cmd
);
  import lrupr_pkg::*;

  localparam idx_t  MY_IDX   = IDX_W'(CELL_INDEX);
  localparam rank_t RANK_MAX = RANK_W'(MAX_FRAMES - 1);

  page_t held_page;
  logic  valid;
  rank_t rank;
  scan_t scan_next;

  always_comb begin
    scan_next = scan_in;
    if (active) begin
      if (!scan_in.found && valid && held_page == page) begin
        scan_next.found      = 1'b1;
        scan_next.found_idx  = MY_IDX;
        scan_next.found_rank = rank;
      end
      if (!scan_in.free && !valid) begin
        scan_next.free     = 1'b1;
        scan_next.free_idx = MY_IDX;
      end
      // highest rank wins, lowest index on a tie
      if (!scan_in.best_set || rank > scan_in.best_rank) begin
        scan_next.best_set  = 1'b1;
        scan_next.best_idx  = MY_IDX;
        scan_next.best_rank = rank;
        scan_next.best_page = held_page;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_next;
    if (cmd.en && active && cmd.miss && cmd.use_idx == MY_IDX) begin
      held_page <= page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.en && active) begin
      if (cmd.use_idx == MY_IDX) begin
        rank <= '0;
        if (cmd.miss) begin
          valid <= 1'b1;
        end
      end else if (valid && (cmd.miss || rank < cmd.limit) && rank != RANK_MAX) begin
        rank <= rank + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/lru_page_replacement.sv
`timescale 1ns / 1ps

// LRU page replacement over MAX_FRAMES frame slots.
// Input channel (in_valid/in_ready, page): one page reference per transfer.
// Output channel (out_valid/out_ready): hit, slot, evicted_valid, evicted_page
// and the saturating fault_count, exactly one result per reference.
// Config channel (cfg_valid/cfg_ready, frames_in_use): always ready; write it
// only while no reference is in flight. 0 acts as 1, above MAX_FRAMES as MAX_FRAMES.
// Each slot is a cell in a chain. A reference is compared by passing a scan
// record down the chain, one cell per cycle, then the update step broadcasts the
// rank and slot update to all cells at once.
// One item is worked on at a time; in_ready is high only while idle.
// A stalled receiver holds the finished item in the update step until the
// output register is free; the result register itself holds until taken.
// Reset (rst, synchronous) empties every slot, clears ranks and the fault
// count, and sets the stored frame count to 8. No clearing pass is needed.
module lru_page_replacement #(
  parameter int MAX_FRAMES = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lrupr_pkg::page_t             page,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic [lrupr_pkg::SLOT_W-1:0] slot,
  output logic                         evicted_valid,
  output lrupr_pkg::page_t             evicted_page,
  output logic [lrupr_pkg::FAULT_W-1:0] fault_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lrupr_pkg::CFG_W-1:0]  frames_in_use
);
  import lrupr_pkg::*;

  localparam int CW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(MAX_FRAMES - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]          state;
  logic [CW-1:0]       cnt;
  page_t               ref_page;
  logic [CFG_W-1:0]    frames;
  logic [FAULT_W-1:0]  faults;
  logic [FAULT_W-1:0]  faults_next;
  logic [MAX_FRAMES-1:0] active;
  scan_t               chain [MAX_FRAMES+1];
  scan_t               result;
  cmd_t                cmd;
  logic                fire;
  idx_t                use_idx;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign chain[0]  = '0;
  assign result    = chain[MAX_FRAMES];

  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      active[i] = (i == 0) || (i < int'(frames));
    end
  end

  generate
    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
      lrupr_cell #(
        .MAX_FRAMES(MAX_FRAMES),
        .CELL_INDEX(g)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .active  (active[g]),
        .page    (ref_page),
        .scan_in (chain[g]),
        .scan_out(chain[g+1]),
        .cmd     (cmd)
      );
    end
  endgenerate

  // resolve the finished scan into one slot
  always_comb begin
    priority if (result.found) begin
      use_idx = result.found_idx;
    end else if (result.free) begin
      use_idx = result.free_idx;
    end else begin
      use_idx = result.best_idx;
    end
  end

  assign fire        = (state == ST_UPDATE) && (!out_valid || out_ready);
  assign cmd.en      = fire;
  assign cmd.miss    = !result.found;
  assign cmd.use_idx = use_idx;
  assign cmd.limit   = result.found_rank;
  assign faults_next = (faults == '1) ? faults : faults + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      frames    <= CFG_W'(FRAMES_RESET);
      faults    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frames <= frames_in_use;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SCAN;
            cnt   <= '0;
          end
        end
        ST_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (fire) begin
            state <= ST_IDLE;
            if (!result.found) begin
              faults <= faults_next;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ref_page <= page;
    end
    if (fire) begin
      hit           <= result.found;
      slot          <= SLOT_W'(use_idx);
      evicted_valid <= !result.found && !result.free;
      evicted_page  <= (!result.found && !result.free) ? result.best_page : '0;
      fault_count   <= result.found ? faults : faults_next;
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a reference is in flight");

  a_evict_only_on_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted_valid))
    else $error("eviction reported on a hit");

  a_fault_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !hit) |-> (fault_count != '0))
    else $error("fault reported with zero fault count");

  a_faults_monotonic: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (faults >= $past(faults)))
    else $error("fault counter went backward");

  a_evicted_page_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !evicted_valid) |-> (evicted_page == '0))
    else $error("evicted page nonzero without eviction");
`endif

endmodule

FILE: sim/lru_page_replacement_tb.sv
`timescale 1ns / 1ps

module lru_page_replacement_tb;
  import lrupr_pkg::*;

  localparam int FRAMES        = 8;
  localparam int SETTLE_CYCLES = FRAMES + 4;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 125;
  localparam int NUM_DIR       = 25;
  localparam int MAX_PRINTS    = 100;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               ev_valid;
    page_t              ev_page;
    logic [FAULT_W-1:0] faults;
  } lookup_res_t;

  typedef enum logic {ROW_REF, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [CFG_W-1:0] frames;
    page_t            pg;
    logic             typed;
    lookup_res_t      want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  page_t               page;
  logic                out_valid;
  logic                out_ready;
  logic                hit;
  logic [SLOT_W-1:0]   slot;
  logic                evicted_valid;
  page_t               evicted_page;
  logic [FAULT_W-1:0]  fault_count;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    frames_in_use;

  // Fill all eight slots, evict the oldest, then shrink, collapse to one
  // frame, grow past the limit (ties), and return to the full count.
  dir_row_t dir_tab [NUM_DIR] = '{
    '{ROW_REF, 4'd0,  8'd0,   1'b1, '{1'b0, 3'd0, 1'b0, 8'd0,   32'd1}},
    '{ROW_REF, 4'd0,  8'd255, 1'b1, '{1'b0, 3'd1, 1'b0, 8'd0,   32'd2}},
    '{ROW_REF, 4'd0,  8'd0,   1'b1, '{1'b1, 3'd0, 1'b0, 8'd0,   32'd2}},
    '{ROW_REF, 4'd0,  8'd1,   1'b1, '{1'b0, 3'd2, 1'b0, 8'd0,   32'd3}},
    '{ROW_REF, 4'd0,  8'd2,   1'b1, '{1'b0, 3'd3, 1'b0, 8'd0,   32'd4}},
    '{ROW_REF, 4'd0,  8'd3,   1'b1, '{1'b0, 3'd4, 1'b0, 8'd0,   32'd5}},
    '{ROW_REF, 4'd0,  8'd4,   1'b1, '{1'b0, 3'd5, 1'b0, 8'd0,   32'd6}},
    '{ROW_REF, 4'd0,  8'd5,   1'b1, '{1'b0, 3'd6, 1'b0, 8'd0,   32'd7}},
    '{ROW_REF, 4'd0,  8'd6,   1'b1, '{1'b0, 3'd7, 1'b0, 8'd0,   32'd8}},
    '{ROW_REF, 4'd0,  8'd128, 1'b1, '{1'b0, 3'd1, 1'b1, 8'd255, 32'd9}},
    '{ROW_REF, 4'd0,  8'd6,   1'b1, '{1'b1, 3'd7, 1'b0, 8'd0,   32'd9}},
    '{ROW_CFG, 4'd3,  8'd0,   1'b0, '0},
    '{ROW_REF, 4'd0,  8'd6,   1'b0, '0},
    '{ROW_REF, 4'd0,  8'd200, 1'b0, '0},
    '{ROW_CFG, 4'd0,  8'd0,   1'b0, '0},
    '{ROW_REF, 4'd0,  8'd7,   1'b0, '0},
    '{ROW_REF, 4'd0,  8'd7,   1'b0, '0},
    '{ROW_REF, 4'd0,  8'd9,   1'b0, '0},
    '{ROW_CFG, 4'd15, 8'd0,   1'b0, '0},
    '{ROW_REF, 4'd0,  8'd3,   1'b0, '0},
    '{ROW_REF, 4'd0,  8'd77,  1'b0, '0},
    '{ROW_REF, 4'd0,  8'd78,  1'b0, '0},
    '{ROW_CFG, 4'd8,  8'd0,   1'b0, '0},
    '{ROW_REF, 4'd0,  8'd6,   1'b0, '0},
    '{ROW_REF, 4'd0,  8'd255, 1'b0, '0}
  };

  logic [CFG_W-1:0] frame_plan [PHASES] = '{
    4'd1, 4'd2, 4'd5, 4'd8, 4'd0, 4'd15, 4'd3, 4'd7, 4'd12, 4'd4, 4'd6, 4'd8
  };

  // Shadow of the resident set
  page_t            res_page  [FRAMES];
  bit               res_valid [FRAMES];
  int               res_rank  [FRAMES];
  logic [FAULT_W-1:0] fault_total;
  logic [CFG_W-1:0] frames_cfg;

  lookup_res_t lookup_q [$];
  int          mismatch_count = 0;
  bit          idle_on;
  int          stall_left;

  lru_page_replacement u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page          (page),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .slot          (slot),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .frames_in_use (frames_in_use)
  );

  always #10 clk = ~clk;

  function automatic int eff_frames();
    int n;
    n = frames_cfg;
    if (n < 1) n = 1;
    if (n > FRAMES) n = FRAMES;
    return n;
  endfunction

  function automatic void age_ranks(input int n, input int skip, input int limit);
    for (int i = 0; i < n; i++) begin
      if (i != skip && res_valid[i] && res_rank[i] < limit && res_rank[i] < FRAMES - 1)
        res_rank[i]++;
    end
  endfunction

  function automatic lookup_res_t predict_lookup(input page_t p);
    lookup_res_t r;
    int          n;
    int          idx;
    bit          found;
    bit          have_free;
    n = eff_frames();
    idx = 0;
    found = 0;
    have_free = 0;
    r = '0;
    for (int i = 0; i < n; i++) begin
      if (!found && res_valid[i] && res_page[i] == p) begin
        idx = i;
        found = 1;
      end
    end
    if (found) begin
      age_ranks(n, idx, res_rank[idx]);
      res_rank[idx] = 0;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!have_free && !res_valid[i]) begin
          idx = i;
          have_free = 1;
        end
      end
      if (!have_free) begin
        // oldest rank wins, lowest slot on a tie
        idx = 0;
        for (int i = 1; i < n; i++)
          if (res_rank[i] > res_rank[idx]) idx = i;
        r.ev_valid = 1'b1;
        r.ev_page  = res_page[idx];
      end
      age_ranks(n, idx, FRAMES);
      res_page[idx]  = p;
      res_valid[idx] = 1;
      res_rank[idx]  = 0;
      if (fault_total != '1) fault_total++;
    end
    r.hit    = found;
    r.slot   = idx[SLOT_W-1:0];
    r.faults = fault_total;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("%t: mismatch: %s", $time, msg);
  endtask

  task automatic send_ref(input page_t p, input logic typed, input lookup_res_t want);
    lookup_res_t predicted;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    page     <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_lookup(p);
    lookup_q.insert(lookup_q.size(), typed ? want : predicted);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] n);
    in_valid <= 1'b0;
    // drain, then let the chain go quiet before touching the count
    while (lookup_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid     <= 1'b1;
    frames_in_use <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    frames_cfg = n;
  endtask

  // Receiver: stall in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_results
    lookup_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (lookup_q.size() == 0) begin
        flag_mismatch("result transfer with no lookup pending");
      end else begin
        want = lookup_q.pop_front();
        if (hit !== want.hit)
          flag_mismatch($sformatf("hit got %0b, expected %0b", hit, want.hit));
        if (slot !== want.slot)
          flag_mismatch($sformatf("slot got %0d, expected %0d", slot, want.slot));
        if (evicted_valid !== want.ev_valid)
          flag_mismatch($sformatf("evicted_valid got %0b, expected %0b",
                                  evicted_valid, want.ev_valid));
        if (evicted_page !== want.ev_page)
          flag_mismatch($sformatf("evicted_page got %0d, expected %0d",
                                  evicted_page, want.ev_page));
        if (fault_count !== want.faults)
          flag_mismatch($sformatf("fault_count got %0d, expected %0d",
                                  fault_count, want.faults));
      end
    end
  end

  initial begin : stimulus
    int    n;
    int    pool;
    page_t base;
    page_t pg;
    rst           = 1'b1;
    in_valid      = 1'b0;
    page          = '0;
    cfg_valid     = 1'b0;
    frames_in_use = '0;
    idle_on       = 1'b1;
    fault_total   = '0;
    frames_cfg    = CFG_W'(FRAMES_RESET);
    for (int i = 0; i < FRAMES; i++) begin
      res_page[i]  = '0;
      res_valid[i] = 0;
      res_rank[i]  = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_CFG) write_frames(dir_tab[r].frames);
      else send_ref(dir_tab[r].pg, dir_tab[r].typed, dir_tab[r].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_on = (ph == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      write_frames(frame_plan[ph]);
      n    = eff_frames();
      pool = n + $urandom_range(0, 4);
      base = page_t'($urandom);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // mostly a working set of the frame count plus up to four more pages
        if ($urandom_range(0, 9) < 7) pg = page_t'(base + $urandom_range(0, pool - 1));
        else pg = page_t'($urandom);
        send_ref(pg, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    while (lookup_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(10_000_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
rtl/lrupr_pkg.sv
rtl/lrupr_cell.sv
rtl/lru_page_replacement.sv
sim/lru_page_replacement_tb.sv
